// ----- hdl/hsfc_pkg.sv -----
// hsfc_pkg: types and constants for the half/single float converter
// no dependencies
`default_nettype none
package hsfc_pkg;
  typedef enum logic {
    OP_S2H = 1'b0,
    OP_H2S = 1'b1
  } op_e;
  localparam logic [7:0] SExpMax = 8'd255;
  localparam logic [7:0] Rebias  = 8'd112;
  localparam logic [4:0] HExpMax = 5'd31;
endpackage
`default_nettype wire

// ----- hdl/half_single_float_converter_unit.sv -----
// half_single_float_converter_unit: binary32 <-> binary16 pattern converter
// depends on hsfc_pkg
//
// Usage:
//   start_i with op_i and operand_bits_i starts a transaction; busy_o is
//   always low, so a transaction is taken in every cycle that start_i is high.
//   op_i = 0 converts a single pattern to half (round to nearest even, half
//   subnormals produced, single subnormals flushed to zero, overflow to
//   infinity); op_i = 1 converts the half in bits 15:0 to single.
//   Operands are registered, the conversion is one combinational pass, and
//   the result is registered: result_bits_o appears with done_o once the
//   transaction has passed the operand and result registers; done_o is
//   high for exactly one cycle and the result is taken while it is high.
//   Throughput is one transaction per cycle, set by the single-pass datapath
//   between the operand and result registers.
//   Reset clears the valid flags of both register stages; no transaction is
//   in flight afterwards. The receiver cannot stall: done_o is a strobe.
`default_nettype none
module half_single_float_converter_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        op_i,
  input  wire logic [31:0] operand_bits_i,
  output logic             done_o,
  output logic [31:0]      result_bits_o
);
  logic        vld_q, done_q;
  hsfc_pkg::op_e op_q;
  logic [31:0] x_q, res_q, res_d;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= start_i;
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q <= hsfc_pkg::op_e'(op_i);
      x_q  <= operand_bits_i;
    end
    if (vld_q) res_q <= res_d;
  end

  // single to half
  logic        s_sign;
  logic [7:0]  s_e;
  logic [22:0] s_m;
  logic [15:0] h_out;
  logic [23:0] full;
  logic [4:0]  sh;
  logic [23:0] rmask;
  logic [10:0] q;
  logic        rbit, stk;
  logic [10:0] t;
  logic [5:0]  ne;

  always_comb begin
    s_sign = x_q[31];
    s_e    = x_q[30:23];
    s_m    = x_q[22:0];
    full   = {1'b1, s_m};
    sh     = 5'd14 + 5'(hsfc_pkg::Rebias - s_e);
    rmask  = (24'd1 << (sh - 5'd1)) - 24'd1;
    rbit   = full[sh - 5'd1];
    stk    = |(full & rmask);
    q      = 11'(full >> sh);
    t      = {1'b0, s_m[22:13]};
    ne     = {1'b0, 5'(s_e - hsfc_pkg::Rebias)};
    h_out  = {s_sign, 15'd0};
    if (s_e == 8'd0) begin
      h_out = {s_sign, 15'd0};
    end else if (s_e == hsfc_pkg::SExpMax) begin
      h_out = (s_m == 23'd0) ? {s_sign, 5'h1f, 10'd0}
                             : {s_sign, 5'h1f, 1'b1, s_m[21:13]};
    end else if (s_e >= 8'd143) begin
      h_out = {s_sign, 5'h1f, 10'd0};
    end else if (s_e <= hsfc_pkg::Rebias) begin
      if (s_e < 8'd102) begin
        h_out = {s_sign, 15'd0};
      end else begin
        if (rbit && (stk || q[0])) q = q + 11'd1;
        h_out = {s_sign, 4'd0, q};
      end
    end else begin
      if (s_m[12] && ((|s_m[11:0]) || t[0])) begin
        t = t + 11'd1;
        if (t[10]) begin
          t  = 11'd0;
          ne = ne + 6'd1;
        end
      end
      if (ne >= 6'd31) h_out = {s_sign, 5'h1f, 10'd0};
      else             h_out = {s_sign, ne[4:0], t[9:0]};
    end
  end

  // half to single
  logic        hs;
  logic [4:0]  he;
  logic [9:0]  hm;
  logic [3:0]  p;
  logic [22:0] nm;
  logic [31:0] s_out;

  always_comb begin
    hs = x_q[15];
    he = x_q[14:10];
    hm = x_q[9:0];
    p  = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (hm[i]) p = 4'(i);
    end
    nm = 23'({hm, 13'd0} << (4'd10 - p));
    if (he == 5'd0) begin
      s_out = (hm == 10'd0) ? {hs, 31'd0} : {hs, 8'(p) + 8'd103, nm};
    end else if (he == hsfc_pkg::HExpMax) begin
      s_out = {hs, 8'hff, hm[9] | (hm != 10'd0), hm[8:0], 13'd0};
    end else begin
      s_out = {hs, 8'(he) + hsfc_pkg::Rebias, hm, 13'd0};
    end
  end

  always_comb begin
    unique case (op_q)
      hsfc_pkg::OP_S2H: res_d = {16'd0, h_out};
      hsfc_pkg::OP_H2S: res_d = s_out;
      default:          res_d = 32'd0;
    endcase
  end

  assign done_o        = done_q;
  assign result_bits_o = res_q;

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> ##1 done_o) else $error("missing done");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 2)) else $error("spurious done");
  a_half_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && op_q == hsfc_pkg::OP_S2H) |=> res_q[31:16] == 16'd0)
    else $error("half upper bits set");
endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// tb: self-checking testbench for half_single_float_converter_unit
// depends on hsfc_pkg and the converter rtl; drives random and directed conversions
`timescale 1ns / 1ps
`default_nettype none
module tb;

  typedef struct packed {
    hsfc_pkg::op_e op;
    logic [31:0]   bits;
  } conv_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        op_i;
  logic [31:0] operand_bits_i;
  logic        done_o;
  logic [31:0] result_bits_o;

  conv_t       pending_q[$];
  logic [31:0] expected_q[$];
  int          errors;
  int          gap;
  int          cycles;
  bit          feed_done;

  half_single_float_converter_unit u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .op_i(op_i), .operand_bits_i(operand_bits_i), .done_o(done_o),
    .result_bits_o(result_bits_o)
  );

  function automatic logic [15:0] to_half(logic [31:0] x);
    logic [15:0] sgn;
    logic [7:0]  e;
    logic [22:0] m;
    logic [23:0] full;
    logic [23:0] rest;
    logic [10:0] q;
    logic [4:0]  sh;
    logic        rb;
    logic        sticky;
    logic [5:0]  ne;
    sgn = {x[31], 15'd0};
    e = x[30:23];
    m = x[22:0];
    if (e == 8'd0) return sgn;
    if (e == hsfc_pkg::SExpMax) begin
      if (m == 23'd0) return sgn | 16'h7C00;
      return sgn | 16'h7E00 | {6'd0, m[22:13]};
    end
    if (e >= 8'd143) return sgn | 16'h7C00;
    if (e <= hsfc_pkg::Rebias) begin
      if (e < 8'd102) return sgn;
      full = {1'b1, m};
      sh = 5'(14 + (112 - e));
      q = 11'(full >> sh);
      rb = full[sh - 1];
      rest = full & ((24'd1 << (sh - 1)) - 24'd1);
      sticky = rest != 24'd0;
      if (rb && (sticky || q[0])) q = q + 11'd1;
      return sgn | {5'd0, q};
    end
    ne = 6'(e - 8'd112);
    q = {1'b0, m[22:13]};
    if (m[12] && (m[11:0] != 12'd0 || q[0])) begin
      q = q + 11'd1;
      if (q[10]) begin
        q = 11'd0;
        ne = ne + 6'd1;
        if (ne >= 6'd31) return sgn | 16'h7C00;
      end
    end
    return sgn | {ne[4:0], q[9:0]};
  endfunction

  function automatic logic [31:0] to_single(logic [15:0] x);
    logic [31:0] sgn;
    logic [4:0]  e;
    logic [9:0]  m;
    int          p;
    logic [31:0] r;
    sgn = {x[15], 31'd0};
    e = x[14:10];
    m = x[9:0];
    if (e == 5'd0) begin
      if (m == 10'd0) return sgn;
      p = 9;
      while (!m[p]) p--;
      r = {22'd0, m} << (23 - p);
      return sgn | (32'(p + 103) << 23) | (r & 32'h007F_FFFF);
    end
    if (e == hsfc_pkg::HExpMax) begin
      r = sgn | 32'h7F80_0000 | ({22'd0, m} << 13);
      if (m != 10'd0) r[22] = 1'b1;
      return r;
    end
    return sgn | (32'(e + 5'd0) + 32'd112) << 23 | ({22'd0, m} << 13);
  endfunction

  function automatic logic [31:0] convert(conv_t c);
    if (c.op == hsfc_pkg::OP_S2H) return {16'd0, to_half(c.bits)};
    return to_single(c.bits[15:0]);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("tb mismatch %s got %08h want %08h", what, got, want);
    errors++;
  endtask

  task automatic push(hsfc_pkg::op_e op, logic [31:0] bits);
    conv_t c;
    c.op = op;
    c.bits = bits;
    pending_q.push_back(c);
  endtask

  function automatic logic [31:0] rand_single();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0: v[30:23] = 8'($urandom_range(101, 113));
      1: v[30:23] = 8'($urandom_range(140, 143));
      2: v[30:23] = $urandom_range(0, 1) ? 8'd0 : 8'd255;
      3: v[12:0] = $urandom_range(0, 1) ? 13'h1000 : 13'h0FFF;
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    logic [31:0] v;
    errors = 0;
    // directed transactions
    push(hsfc_pkg::OP_S2H, 32'h0000_0000);
    push(hsfc_pkg::OP_S2H, 32'h8000_0001);
    push(hsfc_pkg::OP_S2H, 32'h7F80_0000);
    push(hsfc_pkg::OP_S2H, 32'hFF80_0000);
    push(hsfc_pkg::OP_S2H, 32'h7FC0_2000);
    push(hsfc_pkg::OP_S2H, 32'hFF80_0001);
    push(hsfc_pkg::OP_S2H, 32'h477F_F000);
    push(hsfc_pkg::OP_S2H, 32'h477F_EFFF);
    push(hsfc_pkg::OP_S2H, 32'h7F7F_FFFF);
    push(hsfc_pkg::OP_S2H, 32'h3380_0000);
    push(hsfc_pkg::OP_S2H, 32'h3300_0001);
    push(hsfc_pkg::OP_S2H, 32'h387F_F000);
    push(hsfc_pkg::OP_S2H, 32'h3F80_1000);
    push(hsfc_pkg::OP_S2H, 32'h3F80_3000);
    push(hsfc_pkg::OP_S2H, 32'hFFFF_FFFF);
    push(hsfc_pkg::OP_H2S, 32'hFFFF_0000);
    push(hsfc_pkg::OP_H2S, 32'h0000_8000);
    push(hsfc_pkg::OP_H2S, 32'h0000_0001);
    push(hsfc_pkg::OP_H2S, 32'h0000_03FF);
    push(hsfc_pkg::OP_H2S, 32'h0000_7C00);
    push(hsfc_pkg::OP_H2S, 32'h0000_FC01);
    push(hsfc_pkg::OP_H2S, 32'h0000_7FFF);
    push(hsfc_pkg::OP_H2S, 32'h0000_7BFF);
    push(hsfc_pkg::OP_H2S, 32'hABCD_3C00);
    for (int i = 0; i < 1800; i++) begin
      if ($urandom_range(0, 1)) push(hsfc_pkg::OP_S2H, rand_single());
      else begin
        v = $urandom;
        if ($urandom_range(0, 3) == 0) v[14:10] = $urandom_range(0, 1) ? 5'd0 : 5'd31;
        push(hsfc_pkg::OP_H2S, v);
      end
    end
    feed_done = 1'b1;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      op_i <= 1'b0;
      operand_bits_i <= 32'd0;
      gap <= 0;
    end else begin
      if (start_i && !busy_o) begin
        expected_q.push_back(convert(conv_t'({op_i, operand_bits_i})));
      end
      if (start_i && busy_o) begin
        start_i <= 1'b1;
      end else if (gap > 0) begin
        gap <= gap - 1;
        start_i <= 1'b0;
      end else if (pending_q.size() > 0) begin
        conv_t c;
        c = pending_q.pop_front();
        start_i <= 1'b1;
        op_i <= c.op;
        operand_bits_i <= c.bits;
        case ($urandom_range(0, 9))
          0, 1: gap <= $urandom_range(1, 3);
          2: gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : 0;
          default: gap <= 0;
        endcase
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        report("unexpected transaction", result_bits_o, 32'd0);
      end else begin
        logic [31:0] want;
        want = expected_q.pop_front();
        if (result_bits_o !== want) report("result_bits", result_bits_o, want);
      end
    end
  end

  initial begin
    cycles = 0;
    fork
      begin
        wait (feed_done);
        @(posedge clk_i);
        while (pending_q.size() > 0 || start_i || expected_q.size() > 0)
          @(posedge clk_i);
        repeat (10) @(posedge clk_i);
        if (errors == 0) begin
          $display("tb: clean");
        end else begin
          $display("tb: errors");
        end
      end
      begin
        while (cycles < 200000) begin
          @(posedge clk_i);
          cycles++;
        end
        $display("tb mismatch timeout");
        $display("tb: errors");
      end
    join_any
    $finish;
  end
endmodule
`default_nettype wire
